[hdl/aes_ctr_byte_stream_cipher_defines.svh]
// assertion macros for the aes counter-mode byte cipher
`ifndef AES_CTR_BYTE_STREAM_CIPHER_DEFINES_SVH
`define AES_CTR_BYTE_STREAM_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define ACB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ACB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ACB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ACB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/acbsc_pkg.sv]
// types, constants and round functions for the aes counter-mode byte cipher
`default_nettype none
package acbsc_pkg;

    localparam int BLOCK_BYTES = 16;

    typedef enum logic [1:0] {
        S_EXPAND,
        S_IDLE,
        S_ENC
    } t_state;

    typedef enum logic [2:0] {
        REG_KEY_SIZE = 3'd0,
        REG_KEY_0    = 3'd1,
        REG_KEY_1    = 3'd2,
        REG_KEY_2    = 3'd3,
        REG_KEY_3    = 3'd4,
        REG_IV_HIGH  = 3'd5,
        REG_IV_LOW   = 3'd6,
        REG_NONE     = 3'd7
    } t_reg_idx;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic [7:0] GF_POLY  = 8'h1b;
    localparam logic [7:0] RCON_ONE = 8'h01;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte 0 of the state sits in the top bits
    function automatic logic [7:0] st_byte(input logic [127:0] st, input int b);
        st_byte = st[127 - 8*b -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] st);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*c + r) -: 8] = SBOX[st_byte(st, 4*((c + r) % 4) + r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] st);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, s;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = st_byte(st, 4*c);
            a1 = st_byte(st, 4*c + 1);
            a2 = st_byte(st, 4*c + 2);
            a3 = st_byte(st, 4*c + 3);
            s  = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 32] = {a0 ^ s ^ gf_dbl(a0 ^ a1), a1 ^ s ^ gf_dbl(a1 ^ a2),
                                   a2 ^ s ^ gf_dbl(a2 ^ a3), a3 ^ s ^ gf_dbl(a3 ^ a0)};
        end
        mix_cols = t;
    endfunction

endpackage
`default_nettype wire

[hdl/aes_ctr_byte_stream_cipher.sv]
// aes counter-mode byte cipher: key schedule sequencer, round-per-cycle core, byte xor
`default_nettype none
// AES-CTR byte cipher (128/192/256-bit keys). Any configuration write, and reset,
// restarts the stream: the key schedule runs one word per cycle (44, 52 or 60
// words) into a round-key memory, the counter reloads from the IV and the byte
// offset clears; no request is taken meanwhile. A byte at a nonzero offset is
// xored with the stored keystream. A byte at offset zero starts a new keystream
// block, which the shared round unit computes one AES round per cycle, one
// round-key row read per round, before its byte goes out. The next request can
// enter at the same edge at which a waiting result is taken.
module aes_ctr_byte_stream_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_call,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_result_byte,
    output logic             o_end_of_call_echo,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_wdata
);
    import acbsc_pkg::*;

    // configuration
    logic [1:0]   r_key_size;
    logic [255:0] r_key;
    logic [127:0] r_iv;
    logic         cfg_hit;

    // sequencer
    t_state       r_state, n_state;
    logic [5:0]   r_wi, n_wi;
    logic [2:0]   r_wj, n_wj;
    logic [7:0]   r_rcon, n_rcon;
    logic [31:0]  r_win [8];
    logic [95:0]  r_row, n_row;
    logic [3:0]   r_nr;
    logic [3:0]   nk;
    logic [3:0]   nr_sel;
    logic [31:0]  new_word, t_word, old_word;

    // round-key memory
    logic [127:0] r_rk_mem [16];
    logic [127:0] r_rk;
    logic         rk_we;
    logic [3:0]   rk_waddr, rk_raddr;

    // datapath
    logic [127:0] r_ctr, n_ctr;
    logic [127:0] r_st, n_st;
    logic [127:0] r_ks, n_ks;
    logic [3:0]   r_off, n_off;
    logic [3:0]   r_rnd, n_rnd;
    logic [7:0]   r_din, n_din;
    logic         r_deoc, n_deoc;
    logic         r_ovalid, n_ovalid;
    logic [7:0]   r_obyte, n_obyte;
    logic         r_oeoc, n_oeoc;
    logic         in_acc;

    assign cfg_hit = i_cfg_we && (t_reg_idx'(i_cfg_idx) != REG_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= '0;
            r_key      <= '0;
            r_iv       <= '0;
        end else if (cfg_hit) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_KEY_SIZE: r_key_size      <= i_cfg_wdata[1:0];
                REG_KEY_0:    r_key[255:192]  <= i_cfg_wdata;
                REG_KEY_1:    r_key[191:128]  <= i_cfg_wdata;
                REG_KEY_2:    r_key[127:64]   <= i_cfg_wdata;
                REG_KEY_3:    r_key[63:0]     <= i_cfg_wdata;
                REG_IV_HIGH:  r_iv[127:64]    <= i_cfg_wdata;
                REG_IV_LOW:   r_iv[63:0]      <= i_cfg_wdata;
                default:      r_iv            <= r_iv;
            endcase
        end
    end

    // code three acts as a 256-bit key
    always_comb begin
        priority if (r_key_size == KEY_128) begin
            nk = 4'd4;  nr_sel = 4'd10;
        end else if (r_key_size == KEY_192) begin
            nk = 4'd6;  nr_sel = 4'd12;
        end else begin
            nk = 4'd8;  nr_sel = 4'd14;
        end
    end

    // key schedule word from the sliding window of the last eight words
    always_comb begin
        t_word = r_win[7];
        unique case (nk)
            4'd4:    old_word = r_win[4];
            4'd6:    old_word = r_win[2];
            default: old_word = r_win[0];
        endcase
        if (r_wj == 3'd0) begin
            t_word = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_wj == 3'd4) begin
            t_word = sub_word(r_win[7]);
        end
        if (r_wi < 6'(nk)) begin
            new_word = r_key[255 - 32*r_wi[2:0] -: 32];
        end else begin
            new_word = old_word ^ t_word;
        end
    end

    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        n_state  = r_state;
        n_wi     = r_wi;
        n_wj     = r_wj;
        n_rcon   = r_rcon;
        n_row    = r_row;
        n_ctr    = r_ctr;
        n_st     = r_st;
        n_ks     = r_ks;
        n_off    = r_off;
        n_rnd    = r_rnd;
        n_din    = r_din;
        n_deoc   = r_deoc;
        n_ovalid = r_ovalid && !i_ready;
        n_obyte  = r_obyte;
        n_oeoc   = r_oeoc;
        rk_we    = 1'b0;
        rk_waddr = r_wi[5:2];
        rk_raddr = r_rnd + 4'd1;
        unique case (r_state)
            S_EXPAND: begin
                n_row = {r_row[63:0], new_word};
                rk_we = (r_wi[1:0] == 2'd3);
                n_wi  = r_wi + 6'd1;
                if (r_wj == 3'(nk - 4'd1)) begin
                    n_wj = 3'd0;
                end else begin
                    n_wj = r_wj + 3'd1;
                end
                if (r_wj == 3'd0 && r_wi >= 6'(nk)) begin
                    n_rcon = gf_dbl(r_rcon);
                end
                if (r_wi == 6'({nr_sel, 2'b11})) begin
                    n_state = S_IDLE;
                    n_ctr   = r_iv;
                    n_off   = '0;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (r_off == 4'd0) begin
                        n_din    = i_data_byte;
                        n_deoc   = i_end_of_call;
                        n_rnd    = '0;
                        rk_raddr = '0;
                        n_state  = S_ENC;
                    end else begin
                        n_ovalid = 1'b1;
                        n_obyte  = i_data_byte ^ r_ks[127 - 8*r_off -: 8];
                        n_oeoc   = i_end_of_call;
                        n_off    = r_off + 4'd1;
                    end
                end
            end
            S_ENC: begin
                n_rnd = r_rnd + 4'd1;
                priority if (r_rnd == 4'd0) begin
                    n_st = r_ctr ^ r_rk;
                end else if (r_rnd != r_nr) begin
                    n_st = mix_cols(sub_shift(r_st)) ^ r_rk;
                end else begin
                    n_ks     = sub_shift(r_st) ^ r_rk;
                    n_ovalid = 1'b1;
                    n_obyte  = r_din ^ n_ks[127:120];
                    n_oeoc   = r_deoc;
                    n_off    = 4'd1;
                    n_ctr    = r_ctr + 128'd1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_EXPAND;
        endcase
        if (cfg_hit) begin
            n_state  = S_EXPAND;
            n_wi     = '0;
            n_wj     = '0;
            n_rcon   = RCON_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_EXPAND;
            r_wi     <= '0;
            r_wj     <= '0;
            r_rcon   <= RCON_ONE;
            r_off    <= '0;
            r_rnd    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wi     <= n_wi;
            r_wj     <= n_wj;
            r_rcon   <= n_rcon;
            r_off    <= n_off;
            r_rnd    <= n_rnd;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_ctr   <= n_ctr;
        r_st    <= n_st;
        r_ks    <= n_ks;
        r_din   <= n_din;
        r_deoc  <= n_deoc;
        r_obyte <= n_obyte;
        r_oeoc  <= n_oeoc;
        r_nr    <= nr_sel;
        if (r_state == S_EXPAND) begin
            for (int k = 0; k < 7; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[7] <= new_word;
        end
    end

    // one row of four round-key words per round
    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            r_rk_mem[rk_waddr] <= {r_row, new_word};
        end
        r_rk <= r_rk_mem[rk_raddr];
    end

    assign o_valid            = r_ovalid;
    assign o_result_byte      = r_obyte;
    assign o_end_of_call_echo = r_oeoc;

    `include "aes_ctr_byte_stream_cipher_defines.svh"

    `ACB_ASSERT_NEXT(a_new_block_starts_enc, i_clk, i_rst_n, in_acc && r_off == 4'd0 && !cfg_hit, r_state == S_ENC)
    `ACB_ASSERT_SAME(a_round_in_range, i_clk, i_rst_n, r_state == S_ENC, r_rnd <= r_nr)
    `ACB_ASSERT_SAME(a_not_ready_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `ACB_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_ovalid && !i_ready, r_ovalid && $stable(r_obyte))

endmodule
`default_nettype wire
